[rtl/core/bvp_pkg.sv]
// Shared constants and types for the vertical bit packer.
package bvp_pkg;

    localparam int LANE_W           = 32;
    localparam int WIDTH_W          = 6;
    localparam int OFF_W            = 5;
    localparam int GROUPS_PER_BLOCK = 32;
    localparam int CNT_W            = $clog2(GROUPS_PER_BLOCK);

    localparam logic [WIDTH_W-1:0] MAX_WIDTH = WIDTH_W'(LANE_W);

    // Per-group control shared by all lanes
    typedef struct packed {
        logic [OFF_W-1:0]   offset;
        logic [WIDTH_W-1:0] rshift;
        logic [LANE_W-1:0]  mask;
        logic               emit;
        logic               spill;
        logic               last;
    } bvp_ctrl_t;

endpackage

[rtl/core/bvp_in_reg.sv]
// Input register stage: holds one accepted group beat until it is processed.
module bvp_in_reg #(
    parameter int DATA_W = 262
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [DATA_W-1:0] in_data,
    input  logic              advance,
    output logic              out_valid,
    output logic [DATA_W-1:0] out_data
);

    logic              valid_reg;
    logic              valid_next;
    logic [DATA_W-1:0] data_reg;

    // Take a new beat when empty or when the held beat moves on this cycle
    assign in_ready   = !valid_reg || advance;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= in_data;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

[rtl/core/bvp_ctrl.sv]
// Block control: held width, running bit offset and group counter.
module bvp_ctrl (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        advance,
    input  logic [bvp_pkg::WIDTH_W-1:0] pack_width,
    output bvp_pkg::bvp_ctrl_t          ctrl
);
    import bvp_pkg::*;

    logic [WIDTH_W-1:0] held_width_reg;
    logic [WIDTH_W-1:0] held_width_next;
    logic [OFF_W-1:0]   bit_offset_reg;
    logic [OFF_W-1:0]   bit_offset_next;
    logic [CNT_W-1:0]   group_count_reg;
    logic [CNT_W-1:0]   group_count_next;

    logic               first;
    logic [WIDTH_W-1:0] sat_width;
    logic [WIDTH_W-1:0] cur_width;
    logic [WIDTH_W-1:0] end_pos;

    // Sample the width on the first group of a block, saturated to the lane width
    assign first     = (group_count_reg == '0);
    assign sat_width = (pack_width > MAX_WIDTH) ? MAX_WIDTH : pack_width;
    assign cur_width = first ? sat_width : held_width_reg;

    // Position of this group's bits in the lane words
    assign end_pos = {1'b0, bit_offset_reg} + cur_width;

    always_comb begin
        ctrl.offset = bit_offset_reg;
        ctrl.rshift = MAX_WIDTH - {1'b0, bit_offset_reg};
        ctrl.mask   = (cur_width >= MAX_WIDTH) ? '1
                    : ((LANE_W'(1) << cur_width) - LANE_W'(1));
        ctrl.spill  = (end_pos > MAX_WIDTH);
        ctrl.emit   = (end_pos >= MAX_WIDTH);
        ctrl.last   = (group_count_reg == CNT_W'(GROUPS_PER_BLOCK - 1));
    end

    // Advance offset and counter once per processed group
    assign held_width_next  = cur_width;
    assign bit_offset_next  = end_pos[OFF_W-1:0];
    assign group_count_next = group_count_reg + CNT_W'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_width_reg  <= '0;
            bit_offset_reg  <= '0;
            group_count_reg <= '0;
        end else if (advance) begin
            held_width_reg  <= held_width_next;
            bit_offset_reg  <= bit_offset_next;
            group_count_reg <= group_count_next;
        end
    end

    // A block always closes on a word boundary
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance && ctrl.last |=> bit_offset_reg == '0 && group_count_reg == '0)
        else $error("block did not end on a word boundary");

    // Full width emits every group
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance && cur_width == MAX_WIDTH |-> ctrl.emit && !ctrl.spill)
        else $error("full-width group did not emit");

    // Zero width never emits
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance && cur_width == '0 |-> !ctrl.emit)
        else $error("zero-width group emitted");

endmodule

[rtl/core/bvp_lane.sv]
// One lane: mask, shift and merge a value into the lane accumulator.
module bvp_lane (
    input  logic                       aclk,
    input  logic                       advance,
    input  bvp_pkg::bvp_ctrl_t         ctrl,
    input  logic [bvp_pkg::LANE_W-1:0] value,
    output logic [bvp_pkg::LANE_W-1:0] word
);
    import bvp_pkg::*;

    logic [LANE_W-1:0] acc_reg;
    logic [LANE_W-1:0] acc_next;
    logic [LANE_W-1:0] masked;

    // Merge the masked value at the running offset
    assign masked = value & ctrl.mask;
    assign word   = (ctrl.offset == '0) ? masked : (acc_reg | (masked << ctrl.offset));

    // Start the next word with the spilled high bits
    assign acc_next = ctrl.spill ? (masked >> ctrl.rshift) : word;

    always_ff @(posedge aclk) begin
        if (advance) begin
            acc_reg <= acc_next;
        end
    end

endmodule

[rtl/core/vertical_bit_packer_8x32.sv]
// Vertical bit packer top level: input register, lane packers and result register.
// Packs blocks of 32 groups of LANES 32-bit values at 0 to 32 bits each, one
// accumulator word per lane. The width is sampled from pack_width on the first
// group of a block (values above 32 count as 32) and held for the block. A
// result beat carries one finished word per lane and is produced whenever the
// lane words fill; m_axis_tlast marks the last word of a block, and a block of
// width 0 produces no beats at all. One group is accepted per clock cycle
// while the result register is free or draining; a group passes through the
// input register and then the result register, with a single pass of mask,
// shift and OR per lane between them.
module vertical_bit_packer_8x32 #(
    parameter int LANES = 8
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // value_lane0 .. value_lane(LANES-1), pack_width, zero pad to bytes
    input  logic [((LANES*bvp_pkg::LANE_W + bvp_pkg::WIDTH_W + 7) / 8) * 8 - 1:0]
                                               s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // word_lane0 .. word_lane(LANES-1)
    output logic [LANES*bvp_pkg::LANE_W-1:0]   m_axis_tdata,
    // block_end
    output logic                               m_axis_tlast
);
    import bvp_pkg::*;

    localparam int WORDS_W = LANES * LANE_W;
    localparam int ITEM_W  = WORDS_W + WIDTH_W;

    logic               in_valid;
    logic [ITEM_W-1:0]  in_data;
    logic               advance;
    bvp_ctrl_t          ctrl;
    logic [WORDS_W-1:0] words;

    logic               m_valid_reg;
    logic               m_valid_next;
    logic [WORDS_W-1:0] m_data_reg;
    logic               m_last_reg;
    logic               load;

    // Hold the accepted group beat
    bvp_in_reg #(
        .DATA_W (ITEM_W)
    ) u_in_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_data   (s_axis_tdata[ITEM_W-1:0]),
        .advance   (advance),
        .out_valid (in_valid),
        .out_data  (in_data)
    );

    // Process a group when the result register is free or draining
    assign advance = in_valid && (!m_valid_reg || m_axis_tready);
    assign load    = advance && ctrl.emit;

    bvp_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .advance    (advance),
        .pack_width (in_data[WORDS_W +: WIDTH_W]),
        .ctrl       (ctrl)
    );

    for (genvar i = 0; i < LANES; i++) begin : g_lane
        bvp_lane u_lane (
            .aclk    (aclk),
            .advance (advance),
            .ctrl    (ctrl),
            .value   (in_data[i*LANE_W +: LANE_W]),
            .word    (words[i*LANE_W +: LANE_W])
        );
    end

    // Result register: load on emit, drop when taken
    always_comb begin
        m_valid_next = m_valid_reg;
        if (load) begin
            m_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_data_reg <= words;
            m_last_reg <= ctrl.last;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tlast  = m_last_reg;

    // A result beat appears only after an emitting group
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(load))
        else $error("result beat without an emitting group");

    // Never overwrite a result beat that is still waiting
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_axis_tready |-> !load)
        else $error("pending result beat overwritten");

endmodule
